@@ sv/dtmr_pkg.sv @@
package dtmr_pkg;

    localparam int unsigned CLOCKS_PER_CYCLE = 4;
    localparam logic [3:0] DELAY_LIMIT = 4'(CLOCKS_PER_CYCLE);

    localparam logic [15:0] DIVIDER_RESET = 16'hABCC;
    localparam logic [7:0]  COUNTER_TOP   = 8'hFF;

    localparam logic [2:0] OP_ADVANCE       = 3'd0;
    localparam logic [2:0] OP_WRITE_DIVIDER = 3'd1;
    localparam logic [2:0] OP_WRITE_COUNTER = 3'd2;
    localparam logic [2:0] OP_WRITE_MODULO  = 3'd3;
    localparam logic [2:0] OP_WRITE_CONTROL = 3'd4;

    typedef struct packed {
        logic [15:0] divider;
        logic [7:0]  counter;
        logic [7:0]  modulo;
        logic [2:0]  control;
        logic        previous_bit;
        logic        ovf_pending;
        logic [3:0]  ovf_delay;
        logic        rld_window;
        logic [3:0]  rld_delay;
    } timer_state_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } seq_state_t;

    // Divider tap picked by control bits 1..0, gated by the enable in bit 2.
    function automatic logic tap_bit(input logic [15:0] div, input logic [2:0] ctrl);
        logic b;
        case (ctrl[1:0])
            2'd0:    b = div[9];
            2'd1:    b = div[3];
            2'd2:    b = div[5];
            2'd3:    b = div[7];
            default: b = 1'b0;
        endcase
        return b & ctrl[2];
    endfunction

endpackage

@@ sv/dtmr_tick.sv @@
module dtmr_tick (
    input  dtmr_pkg::timer_state_t cur,
    output dtmr_pkg::timer_state_t nxt,
    output logic                   irq
);

    logic now_bit;

    always_comb
    begin
        nxt = cur;
        irq = 1'b0;

        if (nxt.rld_window)
        begin
            nxt.rld_delay = nxt.rld_delay + 4'd1;
            if (nxt.rld_delay > dtmr_pkg::DELAY_LIMIT)
                nxt.rld_window = 1'b0;
        end

        nxt.divider = nxt.divider + 16'd1;
        now_bit = dtmr_pkg::tap_bit(nxt.divider, nxt.control);

        // count on a falling edge of the gated tap
        if (nxt.previous_bit && !now_bit)
        begin
            if (nxt.counter == dtmr_pkg::COUNTER_TOP)
            begin
                nxt.ovf_pending = 1'b1;
                nxt.ovf_delay   = 4'd0;
            end
            nxt.counter = nxt.counter + 8'd1;
        end

        if (nxt.ovf_pending)
        begin
            nxt.ovf_delay = nxt.ovf_delay + 4'd1;
            if (nxt.ovf_delay > dtmr_pkg::DELAY_LIMIT)
            begin
                nxt.ovf_pending = 1'b0;
                // reload only if nothing overwrote the counter meanwhile
                if (nxt.counter == 8'd0)
                begin
                    nxt.counter = nxt.modulo;
                    irq         = 1'b1;
                end
                nxt.rld_window = 1'b1;
                nxt.rld_delay  = 4'd0;
            end
        end

        nxt.previous_bit = now_bit;
    end

endmodule

@@ sv/divider_timer_modulo_reload_core.sv @@
// Advance item of N clocks: one emulated clock per cycle through the tick unit, result
// valid on the cycle after the last; with N = 0, result timing is as for write items.
// Write items: result valid on the cycle after the transfer. One item at a time; the
// next item is taken the cycle after the result transfers.
// Reset: asynchronous, active low; divider to 0xABCC, all other timer state to zero.
module divider_timer_modulo_reload_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  data,
    input  logic [7:0]  clocks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] divider_value,
    output logic [7:0]  counter_value,
    output logic        timer_interrupt,
    output logic        reload_busy
);

    dtmr_pkg::timer_state_t tstate_reg, tstate_next;
    dtmr_pkg::timer_state_t tick_out;
    dtmr_pkg::seq_state_t   seq_reg, seq_next;
    logic [7:0]             remain_reg, remain_next;
    logic                   irq_reg, irq_next;
    logic                   tick_irq;
    logic                   in_xfer;

    dtmr_tick u_tick (
        .cur (tstate_reg),
        .nxt (tick_out),
        .irq (tick_irq)
    );

    assign in_ready  = (seq_reg == dtmr_pkg::ST_IDLE);
    assign out_valid = (seq_reg == dtmr_pkg::ST_DONE);
    assign in_xfer   = in_valid && in_ready;

    assign divider_value   = tstate_reg.divider;
    assign counter_value   = tstate_reg.counter;
    assign timer_interrupt = irq_reg;
    assign reload_busy     = tstate_reg.rld_window;

    always_comb
    begin
        tstate_next = tstate_reg;
        seq_next    = seq_reg;
        remain_next = remain_reg;
        irq_next    = irq_reg;

        case (seq_reg)
            dtmr_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    irq_next = 1'b0;
                    seq_next = dtmr_pkg::ST_DONE;
                    case (op)
                        dtmr_pkg::OP_ADVANCE:
                        begin
                            if (clocks != 8'd0)
                            begin
                                remain_next = clocks;
                                seq_next    = dtmr_pkg::ST_RUN;
                            end
                        end
                        dtmr_pkg::OP_WRITE_DIVIDER:
                            tstate_next.divider = 16'd0;
                        dtmr_pkg::OP_WRITE_COUNTER:
                        begin
                            if (!tstate_reg.rld_window)
                                tstate_next.counter = data;
                        end
                        dtmr_pkg::OP_WRITE_MODULO:
                        begin
                            tstate_next.modulo = data;
                            if (tstate_reg.rld_window)
                                tstate_next.counter = data;
                        end
                        dtmr_pkg::OP_WRITE_CONTROL:
                            tstate_next.control = data[2:0];
                        default:
                            tstate_next = tstate_reg;
                    endcase
                end
            end
            dtmr_pkg::ST_RUN:
            begin
                // advance one emulated clock per cycle
                tstate_next = tick_out;
                irq_next    = irq_reg | tick_irq;
                remain_next = remain_reg - 8'd1;
                if (remain_reg == 8'd1)
                    seq_next = dtmr_pkg::ST_DONE;
            end
            dtmr_pkg::ST_DONE:
            begin
                if (out_ready)
                    seq_next = dtmr_pkg::ST_IDLE;
            end
            default:
                seq_next = dtmr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg                 <= dtmr_pkg::ST_IDLE;
            remain_reg              <= 8'd0;
            irq_reg                 <= 1'b0;
            tstate_reg.divider      <= dtmr_pkg::DIVIDER_RESET;
            tstate_reg.counter      <= 8'd0;
            tstate_reg.modulo       <= 8'd0;
            tstate_reg.control      <= 3'd0;
            tstate_reg.previous_bit <= 1'b0;
            tstate_reg.ovf_pending  <= 1'b0;
            tstate_reg.ovf_delay    <= 4'd0;
            tstate_reg.rld_window   <= 1'b0;
            tstate_reg.rld_delay    <= 4'd0;
        end
        else
        begin
            seq_reg    <= seq_next;
            remain_reg <= remain_next;
            irq_reg    <= irq_next;
            tstate_reg <= tstate_next;
        end
    end

endmodule

@@ sim/divider_timer_modulo_reload_core_tb.sv @@
module divider_timer_modulo_reload_core_tb;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [2:0] CTRL_ENABLE    = 3'b100;
    localparam logic [2:0] CTRL_TAP_BIT3  = 3'b001;
    localparam int TAP_INDEX [4] = '{9, 3, 5, 7};
    localparam int IDLE_PERCENT  = 16;
    localparam int RANDOM_ITEMS  = 800;
    localparam int QUIET_FIRST   = 350;
    localparam int QUIET_LAST    = 500;
    localparam int HOLD_AT       = 600;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 300;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic [7:0] clocks;
    } timer_cmd_t;

    typedef struct packed {
        logic [15:0] divider;
        logic [7:0]  counter;
        logic        irq;
        logic        busy;
    } timer_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = dtmr_pkg::OP_ADVANCE;
    logic [7:0]  data = 8'h00;
    logic [7:0]  clocks = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] divider_value;
    logic [7:0]  counter_value;
    logic        timer_interrupt;
    logic        reload_busy;

    // Timer state as the block should hold it
    logic [15:0] div_q;
    logic [7:0]  cnt_q;
    logic [7:0]  mod_q;
    logic [2:0]  ctrl_q;
    logic        prev_tap;
    logic        ovf_pend;
    logic [3:0]  ovf_dly;
    logic        win_open;
    logic [3:0]  win_dly;

    timer_cmd_t    cmd_queue[$];
    timer_result_t timer_results[$];
    timer_cmd_t    next_cmd;
    timer_result_t got_result;
    int            queued_items = 0;
    int            accepted_items = 0;
    int            checked_results = 0;
    int            error_count = 0;
    int            hold_left;
    logic          hold_done;

    divider_timer_modulo_reload_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .data            (data),
        .clocks          (clocks),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .divider_value   (divider_value),
        .counter_value   (counter_value),
        .timer_interrupt (timer_interrupt),
        .reload_busy     (reload_busy)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic timer_reset();
        div_q    = dtmr_pkg::DIVIDER_RESET;
        cnt_q    = '0;
        mod_q    = '0;
        ctrl_q   = '0;
        prev_tap = 1'b0;
        ovf_pend = 1'b0;
        ovf_dly  = '0;
        win_open = 1'b0;
        win_dly  = '0;
    endtask

    task automatic timer_apply(input logic [2:0] cmd_op, input logic [7:0] cmd_data,
                               input logic [7:0] cmd_clocks);
        timer_result_t res;
        logic          tap_now;
        res.irq = 1'b0;
        case (cmd_op)
            dtmr_pkg::OP_ADVANCE:
            begin
                for (int n = 0; n < cmd_clocks; n++)
                begin
                    if (win_open)
                    begin
                        win_dly = win_dly + 4'd1;
                        if (win_dly > dtmr_pkg::DELAY_LIMIT)
                            win_open = 1'b0;
                    end
                    div_q   = div_q + 16'd1;
                    tap_now = div_q[TAP_INDEX[ctrl_q[1:0]]] && ((ctrl_q & CTRL_ENABLE) != 0);
                    if (prev_tap && !tap_now)
                    begin
                        // wrap arms the delayed reload, restarting its delay
                        if (cnt_q == dtmr_pkg::COUNTER_TOP)
                        begin
                            ovf_pend = 1'b1;
                            ovf_dly  = '0;
                        end
                        cnt_q = cnt_q + 8'd1;
                    end
                    if (ovf_pend)
                    begin
                        ovf_dly = ovf_dly + 4'd1;
                        if (ovf_dly > dtmr_pkg::DELAY_LIMIT)
                        begin
                            ovf_pend = 1'b0;
                            // a counter rewritten meanwhile suppresses reload and interrupt
                            if (cnt_q == 8'd0)
                            begin
                                cnt_q   = mod_q;
                                res.irq = 1'b1;
                            end
                            win_open = 1'b1;
                            win_dly  = '0;
                        end
                    end
                    prev_tap = tap_now;
                end
            end
            dtmr_pkg::OP_WRITE_DIVIDER:
                div_q = '0;
            dtmr_pkg::OP_WRITE_COUNTER:
            begin
                if (!win_open)
                    cnt_q = cmd_data;
            end
            dtmr_pkg::OP_WRITE_MODULO:
            begin
                mod_q = cmd_data;
                if (win_open)
                    cnt_q = cmd_data;
            end
            dtmr_pkg::OP_WRITE_CONTROL:
                ctrl_q = cmd_data[2:0];
            default:
                ;
        endcase
        res.divider = div_q;
        res.counter = cnt_q;
        res.busy    = win_open;
        timer_results = {timer_results, res};
    endtask

    task automatic add_cmd(input logic [2:0] cmd_op, input logic [7:0] cmd_data,
                           input logic [7:0] cmd_clocks);
        timer_cmd_t c;
        c.op     = cmd_op;
        c.data   = cmd_data;
        c.clocks = cmd_clocks;
        cmd_queue = {cmd_queue, c};
        queued_items++;
    endtask

    // Line the counter up just below wrap on the fast tap, then poke at the
    // pending reload and the window that follows it.
    task automatic add_reload_sequence();
        int tail;
        add_cmd(dtmr_pkg::OP_WRITE_DIVIDER, 8'($urandom), 8'($urandom));
        add_cmd(dtmr_pkg::OP_WRITE_CONTROL, {5'($urandom), CTRL_ENABLE | CTRL_TAP_BIT3},
                8'($urandom));
        add_cmd(dtmr_pkg::OP_WRITE_MODULO, 8'($urandom), 8'($urandom));
        add_cmd(dtmr_pkg::OP_WRITE_COUNTER,
                dtmr_pkg::COUNTER_TOP - 8'($urandom_range(0, 1)), 8'($urandom));
        add_cmd(dtmr_pkg::OP_ADVANCE, 8'($urandom), 8'($urandom_range(10, 24)));
        tail = $urandom_range(2, 6);
        repeat (tail)
        begin
            case ($urandom_range(0, 3))
                0: add_cmd(dtmr_pkg::OP_WRITE_COUNTER, 8'($urandom), 8'($urandom));
                1: add_cmd(dtmr_pkg::OP_WRITE_MODULO, 8'($urandom), 8'($urandom));
                default: add_cmd(dtmr_pkg::OP_ADVANCE, 8'($urandom), 8'($urandom_range(0, 3)));
            endcase
        end
    endtask

    task automatic add_noise_item();
        logic [2:0] cmd_op;
        logic [7:0] cmd_clocks;
        cmd_op = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 70)
            cmd_clocks = 8'($urandom_range(0, 40));
        else
            cmd_clocks = 8'($urandom);
        add_cmd(cmd_op, 8'($urandom), cmd_clocks);
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op       <= dtmr_pkg::OP_ADVANCE;
            data     <= 8'h00;
            clocks   <= 8'h00;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                timer_apply(op, data, clocks);
                accepted_items++;
            end
            if (!in_valid || in_ready)
            begin
                if (cmd_queue.size() != 0 &&
                    !((accepted_items < QUIET_FIRST || accepted_items >= QUIET_LAST) &&
                      $urandom_range(0, 99) < IDLE_PERCENT))
                begin
                    next_cmd = cmd_queue.pop_front();
                    in_valid <= 1'b1;
                    op       <= next_cmd.op;
                    data     <= next_cmd.data;
                    clocks   <= next_cmd.clocks;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && checked_results >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (timer_results.size() == 0)
                begin
                    $error("result transfer with no expected result pending");
                    error_count++;
                end
                else
                begin
                    got_result = timer_results.pop_front();
                    if (divider_value !== got_result.divider)
                    begin
                        $error("divider_value: expected %h, got %h",
                               got_result.divider, divider_value);
                        error_count++;
                    end
                    if (counter_value !== got_result.counter)
                    begin
                        $error("counter_value: expected %h, got %h",
                               got_result.counter, counter_value);
                        error_count++;
                    end
                    if (timer_interrupt !== got_result.irq)
                    begin
                        $error("timer_interrupt: expected %b, got %b",
                               got_result.irq, timer_interrupt);
                        error_count++;
                    end
                    if (reload_busy !== got_result.busy)
                    begin
                        $error("reload_busy: expected %b, got %b",
                               got_result.busy, reload_busy);
                        error_count++;
                    end
                end
                checked_results++;
            end
            out_ready <= (hold_left == 0) &&
                         !((checked_results < QUIET_FIRST || checked_results >= QUIET_LAST) &&
                           $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    initial
    begin
        timer_reset();

        // Directed: reset view, spare ops, field extremes, control masking
        add_cmd(dtmr_pkg::OP_ADVANCE, 8'hFF, 8'h00);
        add_cmd(OP_SPARE_FIRST, 8'hFF, 8'hFF);
        add_cmd(OP_SPARE_FIRST + 3'd1, 8'h00, 8'h00);
        add_cmd(OP_SPARE_LAST, 8'hA5, 8'h5A);
        add_cmd(dtmr_pkg::OP_WRITE_MODULO, 8'hFF, 8'h00);
        add_cmd(dtmr_pkg::OP_WRITE_COUNTER, 8'h00, 8'hFF);
        add_cmd(dtmr_pkg::OP_WRITE_CONTROL, 8'hFF, 8'h00);
        add_cmd(dtmr_pkg::OP_ADVANCE, 8'h00, 8'hFF);
        add_cmd(dtmr_pkg::OP_ADVANCE, 8'hFF, 8'h01);
        add_cmd(dtmr_pkg::OP_WRITE_CONTROL, 8'hF8, 8'hFF);
        add_cmd(dtmr_pkg::OP_ADVANCE, 8'h00, 8'hFF);
        // Overflow, then a counter write before the reload is due: no interrupt
        add_cmd(dtmr_pkg::OP_WRITE_CONTROL, {5'h00, CTRL_ENABLE | CTRL_TAP_BIT3}, 8'h00);
        add_cmd(dtmr_pkg::OP_WRITE_DIVIDER, 8'hFF, 8'hFF);
        add_cmd(dtmr_pkg::OP_WRITE_MODULO, 8'hAB, 8'h00);
        add_cmd(dtmr_pkg::OP_WRITE_COUNTER, 8'hFF, 8'h00);
        add_cmd(dtmr_pkg::OP_ADVANCE, 8'h00, 8'd18);
        add_cmd(dtmr_pkg::OP_WRITE_COUNTER, 8'h11, 8'h00);
        add_cmd(dtmr_pkg::OP_ADVANCE, 8'h00, 8'd3);
        // Inside the window: counter write dropped, modulo write loads counter
        add_cmd(dtmr_pkg::OP_WRITE_COUNTER, 8'h22, 8'h00);
        add_cmd(dtmr_pkg::OP_WRITE_MODULO, 8'h00, 8'h00);
        add_cmd(dtmr_pkg::OP_ADVANCE, 8'h00, 8'd8);
        // Clean overflow reloading from a zero modulo
        add_cmd(dtmr_pkg::OP_WRITE_COUNTER, 8'hFF, 8'h00);
        add_cmd(dtmr_pkg::OP_WRITE_DIVIDER, 8'h00, 8'h00);
        add_cmd(dtmr_pkg::OP_ADVANCE, 8'h00, 8'd24);
        add_cmd(dtmr_pkg::OP_ADVANCE, 8'h00, 8'h00);

        while (queued_items < RANDOM_ITEMS + 25)
        begin
            if ($urandom_range(0, 99) < 60)
                add_reload_sequence();
            else
                add_noise_item();
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (timer_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && timer_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ divider_timer_modulo_reload_core.f @@
sv/dtmr_pkg.sv
sv/dtmr_tick.sv
sv/divider_timer_modulo_reload_core.sv
sim/divider_timer_modulo_reload_core_tb.sv
